// ===== rtl/tgs_pkg.sv =====
// ----------------------------------------------------------------------------
// tgs_pkg: shared constants and types for the trilinear grid sampler
// Widths of the fixed-point formats, register codes and the operation enum.
// ----------------------------------------------------------------------------
package tgs_pkg;
  localparam int MAX_DIM_DEF   = 32;
  localparam int FRAC_BITS_DEF = 8;
  localparam int VAL_W         = 16;
  localparam int IDX_W         = 5;
  localparam int SIZE_W        = 6;
  localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 6'd32;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  localparam logic [0:0] REG_GRID_SIZE = 1'b0;
endpackage

// ===== rtl/tgs_ram.sv =====
// ----------------------------------------------------------------------------
// tgs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when re low.
// ----------------------------------------------------------------------------
module tgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/tgs_blend.sv =====
// ----------------------------------------------------------------------------
// tgs_blend: one registered linear blend stage
// Computes a*(1-f) + b*f as a + (b-a)*f, one multiplier, registered output.
// ----------------------------------------------------------------------------
module tgs_blend #(
  parameter int IN_W  = 16,
  parameter int FRAC  = 8
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [IN_W-1:0] a,
  input  logic signed [IN_W-1:0] b,
  input  logic [FRAC-1:0]       f,
  output logic signed [IN_W+FRAC-1:0] y
);
  logic signed [IN_W:0]        diff;
  logic signed [IN_W+FRAC:0]   prod;
  logic signed [IN_W+FRAC:0]   sum;

  // blend with one multiply; result fits since blend is convex
  always_comb begin
    diff = $signed({b[IN_W-1], b}) - $signed({a[IN_W-1], a});
    prod = diff * $signed({1'b0, f});
    sum  = prod + ($signed({a, {FRAC{1'b0}}}) );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= sum[IN_W+FRAC-1:0];
    end
  end
endmodule

// ===== rtl/trilinear_grid_sampler_top.sv =====
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_top: trilinear sampler over a cubic Q-format grid
// ----------------------------------------------------------------------------
// Use: send beats on the input channel; operation=0 stores voxel_value at
// (voxel_x, voxel_y, voxel_z), operation=1 samples the point coord_x/y/z.
// Each sample beat yields one sample_value beat; a write beat yields none.
// Voxels outside 0..grid_size-1 read as zero; grid_size is set over APB
// (byte address 0) and clamps to MAX_DIM.
// Throughput: one beat per cycle while the receiver does not stall. Between
// input accept and output valid lie the RAM read, x blend, y blend and z blend
// registers; bank addresses are formed in the accept cycle. The grid is
// split into eight parity banks (x,y,z low bits) so all eight neighbours are
// read together, one RAM port each.
// Reset: grid_size returns to 32, the pipeline empties; grid contents stay
// undefined until written. When the receiver stalls, the whole pipeline
// holds; ready drops only while the output register is full and stalled.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_top
  import tgs_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    ready,
  input  logic                    operation,
  input  logic [IDX_W-1:0]        voxel_x,
  input  logic [IDX_W-1:0]        voxel_y,
  input  logic [IDX_W-1:0]        voxel_z,
  input  logic signed [VAL_W-1:0] voxel_value,
  input  logic signed [VAL_W-1:0] coord_x,
  input  logic signed [VAL_W-1:0] coord_y,
  input  logic signed [VAL_W-1:0] coord_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] sample_value,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  localparam int HALF   = (MAX_DIM + 1) / 2;
  localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int BDEPTH = 1 << (3 * HW);
  localparam int BAW    = 3 * HW;
  localparam int IW     = VAL_W;
  localparam int W1     = VAL_W + FRAC_BITS;
  localparam int W2     = W1 + FRAC_BITS;
  localparam int W3     = W2 + FRAC_BITS;

  // ---------------- configuration ----------------
  logic [SIZE_W-1:0] grid_size;
  logic [SIZE_W:0]   size_use;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
    end else if (psel && penable && pwrite && paddr == {REG_GRID_SIZE, 1'b0}) begin
      grid_size <= pwdata[SIZE_W-1:0];
    end
  end
  assign prdata = (paddr == {REG_GRID_SIZE, 1'b0}) ? 32'(grid_size) : 32'd0;
  assign size_use = ({1'b0, grid_size} > (SIZE_W+1)'(MAX_DIM)) ?
                    (SIZE_W+1)'(MAX_DIM) : {1'b0, grid_size};

  // ---------------- pipeline control ----------------
  logic adv;
  logic v0, v1, v2, v3;
  assign adv   = !out_valid || out_ready;
  assign ready = adv;
  assign out_valid = v3;

  logic acc_in, smp_in, wr_in;
  assign acc_in = valid && ready;
  assign smp_in = acc_in && (operation == OP_SAMPLE);
  assign wr_in  = acc_in && (operation == OP_WRITE) &&
                  (32'(voxel_x) < MAX_DIM) && (32'(voxel_y) < MAX_DIM) &&
                  (32'(voxel_z) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3} <= '0;
    end else if (adv) begin
      v0 <= smp_in;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // ---------------- stage 0: split coordinates, bank addresses ----------------
  logic signed [IW-1:0] ci [3];
  logic [FRAC_BITS-1:0] cf [3];
  always_comb begin
    ci[0] = IW'($signed(coord_x) >>> FRAC_BITS);
    ci[1] = IW'($signed(coord_y) >>> FRAC_BITS);
    ci[2] = IW'($signed(coord_z) >>> FRAC_BITS);
    cf[0] = coord_x[FRAC_BITS-1:0];
    cf[1] = coord_y[FRAC_BITS-1:0];
    cf[2] = coord_z[FRAC_BITS-1:0];
  end

  // per axis, per offset: in-range flag and halved index for each parity
  logic          inr  [3][2];
  logic [HW-1:0] bidx [3][2];
  logic          lpar [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int o = 0; o < 2; o++) begin
        logic signed [IW:0] p;
        logic signed [IW:0] e;
        p = {ci[a][IW-1], ci[a]} + (IW+1)'(o);
        inr[a][o] = (p >= 0) && (p < $signed({1'b0, (IW)'(size_use)}));
        // bank holds index with parity = bit0; o-th neighbour of parity q
        e = p;
        bidx[a][o] = HW'(e >>> 1);
      end
      lpar[a] = ci[a][0];
    end
  end

  // bank b (bits zyx parity) reads neighbour offset o = parity(b) ^ lpar
  logic [BAW-1:0] raddr [8];
  logic           rin0  [8];
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic ox, oy, oz;
      ox = b[0] ^ lpar[0];
      oy = b[1] ^ lpar[1];
      oz = b[2] ^ lpar[2];
      raddr[b] = {bidx[0][ox], bidx[1][oy], bidx[2][oz]};
      rin0[b]  = inr[0][ox] && inr[1][oy] && inr[2][oz];
    end
  end

  logic [BAW-1:0] waddr;
  logic [2:0]     wbank;
  assign waddr = {HW'(voxel_x >> 1), HW'(voxel_y >> 1), HW'(voxel_z >> 1)};
  assign wbank = {voxel_z[0], voxel_y[0], voxel_x[0]};

  logic [FRAC_BITS-1:0] f1 [3];
  logic [2:0] lp1;
  logic rin1 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) f1[a] <= cf[a];
      lp1 <= {lpar[2], lpar[1], lpar[0]};
      for (int b = 0; b < 8; b++) rin1[b] <= rin0[b];
    end
  end

  // ---------------- stage 1: eight bank reads ----------------
  logic signed [VAL_W-1:0] rd [8];
  for (genvar b = 0; b < 8; b++) begin : g_bank
    tgs_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH)) u_ram (
      .clk  (clk),
      .we   (wr_in && wbank == 3'(b)),
      .waddr(waddr),
      .wdata(voxel_value),
      .re   (adv),
      .raddr(raddr[b]),
      .rdata(rd[b])
    );
  end

  // map banks to corner (dx,dy,dz), zeroing out-of-range corners
  logic signed [VAL_W-1:0] cv [8];
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      logic [2:0] bk;
      bk = 3'(c) ^ lp1;
      cv[c] = rin1[bk] ? rd[bk] : '0;
    end
  end

  // ---------------- stage 2..4: blend x, y, z ----------------
  logic signed [W1-1:0] bx [4];
  logic signed [W2-1:0] by [2];
  logic signed [W3-1:0] bz;
  logic [FRAC_BITS-1:0] fy2, fz2, fz3;
  always_ff @(posedge clk) begin
    if (adv) begin
      fy2 <= f1[1];
      fz2 <= f1[2];
      fz3 <= fz2;
    end
  end

  // corner index c = {dz,dy,dx}; bx[j] with j = {dz,dy}
  for (genvar j = 0; j < 4; j++) begin : g_bx
    tgs_blend #(.IN_W(VAL_W), .FRAC(FRAC_BITS)) u_bx (
      .clk(clk), .en(adv), .a(cv[2*j]), .b(cv[2*j+1]), .f(f1[0]), .y(bx[j]));
  end
  for (genvar j = 0; j < 2; j++) begin : g_by
    tgs_blend #(.IN_W(W1), .FRAC(FRAC_BITS)) u_by (
      .clk(clk), .en(adv), .a(bx[2*j]), .b(bx[2*j+1]), .f(fy2), .y(by[j]));
  end
  tgs_blend #(.IN_W(W2), .FRAC(FRAC_BITS)) u_bz (
    .clk(clk), .en(adv), .a(by[0]), .b(by[1]), .f(fz3), .y(bz));

  // floor to sample format
  assign sample_value = bz[3*FRAC_BITS +: VAL_W];
endmodule

// ===== rtl/tgs_checker.sv =====
// ----------------------------------------------------------------------------
// tgs_checker: port-level checks for the trilinear grid sampler
// Watches handshakes and configuration on the top-level ports.
// ----------------------------------------------------------------------------
module tgs_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic operation,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] sample_value,
  input logic pready
);
  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_value))
    else $error("output beat changed under stall");

  // ready is high whenever the output side is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready)
    else $error("input stalled with empty output");

  // an input beat waiting for ready holds its valid and operation
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(operation))
    else $error("input beat dropped while stalled");

  // config port never waits
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind trilinear_grid_sampler_top tgs_checker u_tgs_checker (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .operation(operation),
  .out_valid(out_valid), .out_ready(out_ready), .sample_value(sample_value),
  .pready(pready)
);

// ===== dv/trilinear_grid_sampler_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_top_test: self-checking bench for the grid sampler
// Writes voxels and samples points through the valid/ready channel, predicts
// every sample beat from a local copy of the grid, and sweeps grid_size over
// the APB port between phases, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_top_test;
  import tgs_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  localparam int FB  = FRAC_BITS_DEF;

  typedef struct {
    op_t                     op;
    logic [IDX_W-1:0]        vx, vy, vz;
    logic signed [VAL_W-1:0] val, cx, cy, cz;
    bit                      has_exp;
    logic signed [VAL_W-1:0] exp_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic operation = OP_WRITE;
  logic [IDX_W-1:0] voxel_x = '0, voxel_y = '0, voxel_z = '0;
  logic signed [VAL_W-1:0] voxel_value = '0, coord_x = '0, coord_y = '0, coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VAL_W-1:0] sample_value;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // local copy of the grid and the register
  logic signed [VAL_W-1:0] grid_copy [DIM*DIM*DIM];
  bit                      grid_written [DIM*DIM*DIM];
  logic [SIZE_W-1:0]       size_reg;
  bit                      fill_random;

  logic signed [VAL_W-1:0] expected_samples [$];
  stim_row_t               directed_rows [$];
  int                      mismatches;
  int                      burst_left;
  int                      hold_cycles;
  int                      stall_mode;

  trilinear_grid_sampler_top dut (.*);

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic note_mismatch(string what, longint exp_v, longint act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  function automatic int grid_limit();
    return (size_reg > DIM) ? DIM : int'(size_reg);
  endfunction

  function automatic int cell_addr(int x, int y, int z);
    return (x * DIM + y) * DIM + z;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    int n;
    n = grid_limit();
    return x >= 0 && x < n && y >= 0 && y < n && z >= 0 && z < n;
  endfunction

  function automatic longint voxel_at(int x, int y, int z);
    if (!in_grid(x, y, z)) return 0;
    return longint'(grid_copy[cell_addr(x, y, z)]);
  endfunction

  function automatic longint lerp(longint a, longint b, longint f);
    return a * ((longint'(1) << FB) - f) + b * f;
  endfunction

  // Full-precision trilinear blend, floored back to the sample format
  function automatic logic signed [VAL_W-1:0] interpolate(
      logic signed [VAL_W-1:0] cx, logic signed [VAL_W-1:0] cy,
      logic signed [VAL_W-1:0] cz);
    int xl, yl, zl;
    longint fx, fy, fz, c00, c01, c10, c11, c0, c1, acc;
    xl = int'(cx) >>> FB;
    yl = int'(cy) >>> FB;
    zl = int'(cz) >>> FB;
    fx = longint'(cx[FB-1:0]);
    fy = longint'(cy[FB-1:0]);
    fz = longint'(cz[FB-1:0]);
    c00 = lerp(voxel_at(xl, yl, zl), voxel_at(xl+1, yl, zl), fx);
    c01 = lerp(voxel_at(xl, yl, zl+1), voxel_at(xl+1, yl, zl+1), fx);
    c10 = lerp(voxel_at(xl, yl+1, zl), voxel_at(xl+1, yl+1, zl), fx);
    c11 = lerp(voxel_at(xl, yl+1, zl+1), voxel_at(xl+1, yl+1, zl+1), fx);
    c0 = lerp(c00, c10, fy);
    c1 = lerp(c01, c11, fy);
    acc = lerp(c0, c1, fz);
    return VAL_W'(acc >>> (3 * FB));
  endfunction

  // Drive one beat and hold it until accepted, then update the prediction
  task automatic send_beat(stim_row_t row);
    int gap;
    @(negedge clk);
    valid       = 1'b1;
    operation   = row.op;
    voxel_x     = row.vx;
    voxel_y     = row.vy;
    voxel_z     = row.vz;
    voxel_value = row.val;
    coord_x     = row.cx;
    coord_y     = row.cy;
    coord_z     = row.cz;
    do @(posedge clk); while (!ready);
    if (row.op == OP_WRITE) begin
      grid_copy[cell_addr(row.vx, row.vy, row.vz)] = row.val;
      grid_written[cell_addr(row.vx, row.vy, row.vz)] = 1'b1;
    end else begin
      expected_samples.push_back(row.has_exp ? row.exp_val
                                             : interpolate(row.cx, row.cy, row.cz));
    end
    // end of burst: pick a new burst length and maybe insert an idle gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Write any in-grid neighbour of the point that was never written
  task automatic prime_neighbors(logic signed [VAL_W-1:0] cx,
      logic signed [VAL_W-1:0] cy, logic signed [VAL_W-1:0] cz);
    int xl, yl, zl;
    stim_row_t w;
    xl = int'(cx) >>> FB;
    yl = int'(cy) >>> FB;
    zl = int'(cz) >>> FB;
    for (int i = 0; i < 8; i++) begin
      if (in_grid(xl + i[2], yl + i[1], zl + i[0]) &&
          !grid_written[cell_addr(xl + i[2], yl + i[1], zl + i[0])]) begin
        w = '{op: OP_WRITE, vx: IDX_W'(xl + i[2]), vy: IDX_W'(yl + i[1]),
              vz: IDX_W'(zl + i[0]), val: fill_random ? VAL_W'($urandom) : '0,
              cx: VAL_W'($urandom), cy: VAL_W'($urandom), cz: VAL_W'($urandom),
              has_exp: 1'b0, exp_val: '0};
        send_beat(w);
      end
    end
  endtask

  task automatic issue(stim_row_t row);
    if (row.op == OP_SAMPLE) prime_neighbors(row.cx, row.cy, row.cz);
    send_beat(row);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_coord();
    int n;
    n = grid_limit();
    if ($urandom_range(0, 9) == 0) return VAL_W'($urandom);
    if ($urandom_range(0, 5) == 0) return VAL_W'($urandom_range(0, n + 1) << FB);
    return VAL_W'(int'($urandom_range(0, (n + 2) << FB)) - (1 << FB));
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    r.op = ($urandom_range(0, 4) == 0) ? OP_WRITE : OP_SAMPLE;
    r.vx = IDX_W'($urandom);
    r.vy = IDX_W'($urandom);
    r.vz = IDX_W'($urandom);
    r.val = VAL_W'($urandom);
    r.cx = pick_coord();
    r.cy = pick_coord();
    r.cz = pick_coord();
    r.has_exp = 1'b0;
    r.exp_val = '0;
    return r;
  endfunction

  // Wait for the pipeline to drain, then set and read back grid_size
  task automatic set_grid_size(logic [SIZE_W-1:0] value);
    @(negedge clk);
    valid = 1'b0;
    wait (expected_samples.size() == 0);
    repeat (10) @(posedge clk);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = 2'(4 * REG_GRID_SIZE); pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    size_reg = value;
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SIZE_W-1:0] !== value) note_mismatch("grid_size readback", value, prdata);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // Receiver: random stall pattern, plus a long hold when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        note_mismatch("unexpected sample_value", 0, sample_value);
      end else begin
        if (sample_value !== expected_samples[0])
          note_mismatch("sample_value", expected_samples[0], sample_value);
        void'(expected_samples.pop_front());
      end
    end
  end

  function automatic stim_row_t wr(int x, int y, int z, int v);
    return '{op: OP_WRITE, vx: IDX_W'(x), vy: IDX_W'(y), vz: IDX_W'(z), val: VAL_W'(v),
             cx: '0, cy: '0, cz: '0, has_exp: 1'b0, exp_val: '0};
  endfunction

  function automatic stim_row_t sm(int x, int y, int z, bit known, int e);
    return '{op: OP_SAMPLE, vx: '1, vy: '1, vz: '1, val: '1, cx: VAL_W'(x),
             cy: VAL_W'(y), cz: VAL_W'(z), has_exp: known, exp_val: VAL_W'(e)};
  endfunction

  initial begin
    logic [SIZE_W-1:0] sizes [6];
    mismatches = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_mode = 1;
    fill_random = 1'b0;
    size_reg = GRID_SIZE_RST;
    foreach (grid_written[i]) grid_written[i] = 1'b0;

    // extremes, integer and half fractions, points far outside the grid
    directed_rows.push_back(wr(0, 0, 0, 32767));
    directed_rows.push_back(wr(31, 31, 31, -32768));
    directed_rows.push_back(wr(1, 0, 0, -32768));
    directed_rows.push_back(sm(0, 0, 0, 1, 32767));
    directed_rows.push_back(sm(31 << FB, 31 << FB, 31 << FB, 1, -32768));
    directed_rows.push_back(sm(-32768, -32768, -32768, 1, 0));
    directed_rows.push_back(sm(32767, 32767, 32767, 1, 0));
    directed_rows.push_back(sm(32 << FB, 0, 0, 1, 0));
    directed_rows.push_back(sm(128, 0, 0, 1, -1));
    directed_rows.push_back(sm(-128, 0, 0, 1, 16383));
    directed_rows.push_back(sm(255, 0, 0, 0, 0));
    directed_rows.push_back(sm(1, 1, 1, 0, 0));
    directed_rows.push_back(wr(31, 0, 31, 12345));
    directed_rows.push_back(wr(0, 31, 0, -1));
    directed_rows.push_back(sm(30 << FB | 200, 100, 30 << FB | 77, 0, 0));
    directed_rows.push_back(sm(-1, 31 << FB | 128, -1, 0, 0));
    directed_rows.push_back(sm((31 << FB) + 255, (31 << FB) + 255, (31 << FB) + 255, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) issue(directed_rows[i]);

    // zero, oversized and single-voxel sizes give known results
    set_grid_size(6'd0);
    issue(sm(0, 0, 0, 1, 0));
    issue(sm(128, 128, 128, 1, 0));
    set_grid_size(6'd63);
    issue(sm(0, 0, 0, 1, 32767));
    issue(sm(31 << FB, 31 << FB, 31 << FB, 1, -32768));
    set_grid_size(6'd1);
    issue(sm(0, 0, 0, 1, 32767));

    fill_random = 1'b1;
    sizes = '{6'd32, 6'd1, 6'd2, 6'd63, 6'd0, 6'd5};
    for (int ph = 0; ph < 6; ph++) begin
      set_grid_size(ph == 5 ? SIZE_W'($urandom_range(3, 40)) : sizes[ph]);
      // long receiver hold while input keeps coming
      if (ph == 0) hold_cycles = 300;
      for (int k = 0; k < 40; k++) issue(random_row());
    end

    @(negedge clk);
    valid = 1'b0;
    wait (expected_samples.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
